>>> src/ofrt_pkg.sv
// ----------------------------------------------------------------------------
// ofrt_pkg
// Shared types and codes for the open-file reference-count table.
// ----------------------------------------------------------------------------
package ofrt_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int RESERVED_DEF = 2;

    localparam int OP_W     = 2;
    localparam int SECTOR_W = 16;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd3;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
    } t_entry;

endpackage

>>> src/ofrt_if.sv
// ----------------------------------------------------------------------------
// ofrt_if
// Request and response channels of the open-file reference-count table.
// ----------------------------------------------------------------------------
interface ofrt_req_if;
    logic                          valid;
    logic                          ready;
    logic [ofrt_pkg::OP_W-1:0]     operation;
    logic [ofrt_pkg::SECTOR_W-1:0] sector;
    logic [ofrt_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, operation, sector, slot, input ready);
    modport sink   (input valid, operation, sector, slot, output ready);
endinterface

interface ofrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ofrt_pkg::STATUS_W-1:0] status;
    logic [ofrt_pkg::SLOT_W-1:0]   slot_out;
    logic                          remove_now;

    modport source (output valid, status, slot_out, remove_now, input ready);
    modport sink   (input valid, status, slot_out, remove_now, output ready);
endinterface

>>> src/open_file_refcount_table.sv
// ----------------------------------------------------------------------------
// open_file_refcount_table
// Open-file table keyed by inode sector with per-slot reference counts.
// Acquire and mark-delete scan the entry memory one slot a cycle through the
//   single read port of the entry memory, stopping at the first hit or after
//   the last slot; the response then waits for the output register to be free.
// Release reads its slot once; a slot not in use goes straight to the response.
// One request in flight; the next is taken once the response is registered.
// Synchronous reset clears valid and pending bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module open_file_refcount_table #(
    parameter int ENTRIES        = ofrt_pkg::ENTRIES_DEF,
    parameter int RESERVED_SLOTS = ofrt_pkg::RESERVED_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ofrt_req_if.sink   i_req,
    ofrt_rsp_if.source o_rsp
);

    localparam int IW = $clog2(ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REL, S_RESP} t_state;

    t_state                         r_state, n_state;
    logic [ofrt_pkg::OP_W-1:0]      r_op, n_op;
    logic [ofrt_pkg::SECTOR_W-1:0]  r_sec, n_sec;
    logic [IW-1:0]                  r_slot, n_slot;
    logic [IW-1:0]                  r_idx, n_idx;
    logic                           r_free_found, n_free_found;
    logic [IW-1:0]                  r_free_idx, n_free_idx;
    logic [ENTRIES-1:0]             r_valid, n_valid;
    logic [ENTRIES-1:0]             r_pend, n_pend;
    logic [ofrt_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic [ofrt_pkg::SLOT_W-1:0]    r_res_slot, n_res_slot;
    logic                           r_res_remove, n_res_remove;
    logic                           r_out_valid, n_out_valid;
    logic [ofrt_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [ofrt_pkg::SLOT_W-1:0]    r_out_slot, n_out_slot;
    logic                           r_out_remove, n_out_remove;

    ofrt_pkg::t_entry mem [ENTRIES];
    ofrt_pkg::t_entry rd_data;
    ofrt_pkg::t_entry mem_wd;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    mem_wa;
    logic             mem_we;

    logic                           in_fire;
    logic                           req_slot_ok;
    logic                           hit;
    logic                           cand;
    logic [IW-1:0]                  fidx;
    logic [ofrt_pkg::COUNT_W-1:0]   dec_count;

    assign i_req.ready      = (r_state == S_IDLE);
    assign in_fire          = i_req.valid && i_req.ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.slot_out   = r_out_slot;
    assign o_rsp.remove_now = r_out_remove;

    assign req_slot_ok = (32'(i_req.slot) < ENTRIES) && r_valid[IW'(i_req.slot)];
    assign hit         = r_valid[r_idx] && (rd_data.sector == r_sec);
    assign cand        = !r_valid[r_idx] && (32'(r_idx) >= RESERVED_SLOTS);
    assign fidx        = r_free_found ? r_free_idx : r_idx;
    assign dec_count   = (rd_data.count == '0) ? '0 :
                         rd_data.count - ofrt_pkg::COUNT_W'(1);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_sec        = r_sec;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_remove = r_res_remove;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_remove = r_out_remove;
        rd_addr      = r_idx + IW'(1);
        mem_we       = 1'b0;
        mem_wa       = r_idx;
        mem_wd       = rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op         = i_req.operation;
                    n_sec        = i_req.sector;
                    n_slot       = IW'(i_req.slot);
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_res_status = ofrt_pkg::ST_OK;
                    n_res_slot   = '0;
                    n_res_remove = 1'b0;
                    unique case (i_req.operation)
                        ofrt_pkg::OP_ACQUIRE, ofrt_pkg::OP_MARK: begin
                            rd_addr = '0;
                            n_state = S_SCAN;
                        end
                        ofrt_pkg::OP_RELEASE: begin
                            rd_addr = IW'(i_req.slot);
                            if (req_slot_ok) begin
                                n_state = S_REL;
                            end else begin
                                n_res_status = ofrt_pkg::ST_NOT_IN_USE;
                                n_state      = S_RESP;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                // remember the first free slot past the reserved ones
                if (cand && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
                if (hit) begin
                    n_state = S_RESP;
                    if (r_op == ofrt_pkg::OP_ACQUIRE) begin
                        if (r_pend[r_idx]) begin
                            n_res_status = ofrt_pkg::ST_REFUSED;
                        end else begin
                            mem_we       = 1'b1;
                            mem_wa       = r_idx;
                            mem_wd.sector = r_sec;
                            mem_wd.count  = (rd_data.count == ofrt_pkg::COUNT_MAX) ?
                                            rd_data.count :
                                            rd_data.count + ofrt_pkg::COUNT_W'(1);
                            n_res_slot   = ofrt_pkg::SLOT_W'(r_idx);
                        end
                    end else begin
                        n_pend[r_idx] = 1'b1;
                    end
                end else if (r_idx == IW'(ENTRIES - 1)) begin
                    n_state = S_RESP;
                    if (r_op == ofrt_pkg::OP_ACQUIRE) begin
                        if (r_free_found || cand) begin
                            mem_we        = 1'b1;
                            mem_wa        = fidx;
                            mem_wd.sector = r_sec;
                            mem_wd.count  = ofrt_pkg::COUNT_W'(1);
                            n_valid[fidx] = 1'b1;
                            n_pend[fidx]  = 1'b0;
                            n_res_slot    = ofrt_pkg::SLOT_W'(fidx);
                        end else begin
                            n_res_status = ofrt_pkg::ST_FULL;
                        end
                    end else begin
                        n_res_remove = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_REL: begin
                n_state = S_RESP;
                if (dec_count == '0) begin
                    n_res_remove    = r_pend[r_slot];
                    n_valid[r_slot] = 1'b0;
                    n_pend[r_slot]  = 1'b0;
                end else begin
                    mem_we       = 1'b1;
                    mem_wa       = r_slot;
                    mem_wd.count = dec_count;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_out_remove = r_res_remove;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_sec        <= n_sec;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_remove <= n_res_remove;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_remove <= n_out_remove;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[rd_addr];
    end

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("request beat did not start processing");

    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ofrt_pkg::ST_FULL) |->
            (r_out_slot == '0 && !r_out_remove))
        else $error("full response carries a slot or remove flag");

    a_remove_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_remove) |-> (r_out_status == ofrt_pkg::ST_OK))
        else $error("remove flag with non-ok status");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_RESP) |-> !mem_we)
        else $error("entry memory written outside a request");

endmodule
